/* rtl/tfpq_pkg.sv */
// tfpq_pkg: shared types and codes for the typed frame pool queue
// no dependencies
`default_nettype none
package tfpq_pkg;
    localparam int unsigned POOL_BLOCKS = 16;
    localparam int unsigned FRAME_BYTES = 32;
    localparam int unsigned TYPE_BITS   = 4;

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_FETCHED = 3'd3,
        ST_NONE    = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] frame_type;
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [4:0] frame_length;
        logic [4:0] frame_count;
        logic [4:0] removed_count;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_WALK,
        S_WALK_CHK,
        S_UNLINK,
        S_RD,
        S_RD_WAIT,
        S_EMIT,
        S_RESULT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic walk_start;
        logic walk_chk;
        logic unlink;
        logic rd_issue;
        logic rd_capture;
        logic emit;
        logic result;
        logic out_take;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic store_result;
        logic walk_end;
        logic match;
        logic is_fetch;
        logic bytes_done;
        logic out_full;
    } t_stat;
endpackage
`default_nettype wire

/* rtl/tfpq_ctrl.sv */
// tfpq_ctrl: sequencer for store, fetch walk, clear walk and byte readout
// depends on tfpq_pkg
`default_nettype none
module tfpq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire            i_out_ready,
    input  wire  [1:0]     i_action,
    input  tfpq_pkg::t_stat i_stat,
    output tfpq_pkg::t_cmd  o_cmd
);
    import tfpq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.out_take = i_out_ready && i_stat.out_full;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    priority case (t_action'(i_action))
                        ACT_STORE: n_state = S_STORE;
                        ACT_FETCH, ACT_CLEAR: begin
                            o_cmd.walk_start = 1'b1;
                            n_state = S_WALK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = i_stat.store_result ? S_OUT : S_IDLE;
            end
            S_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.result = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                o_cmd.walk_chk = 1'b1;
                if (i_stat.match) begin
                    n_state = S_UNLINK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state = i_stat.is_fetch ? S_RD : S_WALK;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_full || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = i_stat.bytes_done ? S_OUT : S_RD;
                end
            end
            S_RESULT: n_state = S_OUT;
            S_OUT: begin
                if (!i_stat.out_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/tfpq_dp.sv */
// tfpq_dp: block pool, link tables, payload memory and output register
// depends on tfpq_pkg
`default_nettype none
module tfpq_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_take,
    input  tfpq_pkg::t_in_item   i_in,
    input  tfpq_pkg::t_cmd       i_cmd,
    output tfpq_pkg::t_stat      o_stat,
    output tfpq_pkg::t_out_item  o_out,
    output logic                 o_out_valid
);
    import tfpq_pkg::*;

    localparam int unsigned BW = $clog2(POOL_BLOCKS + 1);
    localparam int unsigned IW = $clog2(POOL_BLOCKS);
    localparam int unsigned LW = $clog2(FRAME_BYTES);
    localparam int unsigned AW = $clog2(POOL_BLOCKS * FRAME_BYTES);
    localparam logic [BW-1:0] NIL = BW'(POOL_BLOCKS);

    logic [7:0]     r_mem [POOL_BLOCKS*FRAME_BYTES];
    logic [BW-1:0]  r_link [POOL_BLOCKS];
    logic [TYPE_BITS-1:0] r_kind [POOL_BLOCKS];
    logic [LW:0]    r_len [POOL_BLOCKS];

    logic [BW-1:0]  r_free, r_head, r_tail, r_fill, r_prev, r_cur;
    logic [BW-1:0]  r_steps;
    logic [4:0]     r_count, r_removed;
    logic [LW:0]    r_flen, r_rlen, r_ridx;
    logic           r_fovf;
    t_in_item       r_in;
    logic [7:0]     r_rdata;
    t_out_item      r_out;
    logic           r_out_v;

    logic [TYPE_BITS-1:0] w_kind_in;
    assign w_kind_in = r_in.frame_type[TYPE_BITS-1:0];

    logic w_cur_ok;
    assign w_cur_ok = r_cur < NIL;

    // output register is loaded by the last byte of a store, a fetched byte or a walk result
    logic w_out_set;
    assign w_out_set = (i_cmd.store && r_in.last_byte) || i_cmd.emit || i_cmd.result;

    assign o_stat.store_result = r_in.last_byte;
    assign o_stat.walk_end = !w_cur_ok || (r_steps >= NIL);
    assign o_stat.match = (r_kind[r_cur[IW-1:0]] == w_kind_in)
                          && (r_len[r_cur[IW-1:0]] != '0);
    assign o_stat.is_fetch = r_in.action == ACT_FETCH;
    assign o_stat.bytes_done = (r_ridx + 1'b1) == r_rlen;
    assign o_stat.out_full = r_out_v;
    assign o_out = r_out;
    assign o_out_valid = r_out_v;

    // payload memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !r_fovf && (r_flen < (LW+1)'(FRAME_BYTES - 1))) begin
            if ((r_flen == '0 ? r_free : r_fill) < NIL)
                r_mem[AW'((r_flen == '0 ? r_free : r_fill) * FRAME_BYTES)
                      + AW'(r_flen)] <= r_in.byte_value;
        end
        if (i_cmd.rd_issue)
            r_rdata <= r_mem[AW'(r_cur * FRAME_BYTES) + AW'(r_ridx)];
    end

    logic [BW-1:0] w_blk;
    logic          w_ovf;
    always_comb begin
        w_blk = (r_flen == '0 && !r_fovf) ? r_free : r_fill;
        w_ovf = r_fovf || (r_flen >= (LW+1)'(FRAME_BYTES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_BLOCKS; i++) r_link[i] <= BW'(i + 1);
            r_free <= '0;
            r_head <= NIL;
            r_tail <= NIL;
            r_fill <= NIL;
            r_count <= '0;
            r_flen <= '0;
            r_fovf <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_out_set) r_out_v <= 1'b1;
            else if (i_cmd.out_take) r_out_v <= 1'b0;
            if (i_in_take) begin
                r_in <= i_in;
                r_prev <= NIL;
                r_cur <= r_head;
                r_steps <= '0;
                r_removed <= '0;
            end
            if (i_cmd.store) begin
                logic [BW-1:0] blk;
                logic [BW-1:0] fh;
                logic          take;
                blk  = w_blk;
                take = (r_flen == '0) && !r_fovf && (r_free < NIL);
                fh   = take ? r_link[r_free[IW-1:0]] : r_free;
                if (!r_in.last_byte) begin
                    if (take) r_link[r_free[IW-1:0]] <= NIL;
                    r_free <= fh;
                    r_fill <= blk;
                    r_fovf <= w_ovf;
                    if (!w_ovf) r_flen <= r_flen + 1'b1;
                end else begin
                    r_out.data_byte <= '0;
                    r_out.frame_length <= '0;
                    r_out.removed_count <= '0;
                    r_out.last <= 1'b1;
                    r_fill <= NIL;
                    r_flen <= '0;
                    r_fovf <= 1'b0;
                    if (w_ovf) begin
                        r_out.status <= ST_DROPPED;
                        r_out.frame_count <= r_count;
                        // block goes back to the head of the free list
                        if (blk < NIL) begin
                            r_link[blk[IW-1:0]] <= fh;
                            r_free <= blk;
                        end
                    end else if (blk >= NIL) begin
                        r_out.status <= ST_FULL;
                        r_out.frame_count <= r_count;
                    end else begin
                        r_out.status <= ST_STORED;
                        r_kind[blk[IW-1:0]] <= w_kind_in;
                        r_len[blk[IW-1:0]] <= r_flen + 1'b1;
                        r_link[blk[IW-1:0]] <= NIL;
                        if (r_tail < NIL) r_link[r_tail[IW-1:0]] <= blk;
                        else r_head <= blk;
                        r_tail <= blk;
                        r_free <= fh;
                        r_count <= r_count + 1'b1;
                        r_out.frame_count <= r_count + 1'b1;
                    end
                end
            end
            if (i_cmd.walk_chk && !o_stat.match) begin
                r_prev <= r_cur;
                r_cur <= r_link[r_cur[IW-1:0]];
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.unlink) begin
                if (r_prev >= NIL) r_head <= r_link[r_cur[IW-1:0]];
                else r_link[r_prev[IW-1:0]] <= r_link[r_cur[IW-1:0]];
                if (r_tail == r_cur) r_tail <= r_prev;
                r_link[r_cur[IW-1:0]] <= r_free;
                r_free <= r_cur;
                if (r_count != '0) r_count <= r_count - 1'b1;
                r_removed <= r_removed + 1'b1;
                // a fetch keeps the block id for readout
                r_cur <= (r_in.action == ACT_FETCH) ? r_cur : r_link[r_cur[IW-1:0]];
                r_steps <= r_steps + 1'b1;
                r_rlen <= r_len[r_cur[IW-1:0]];
                r_ridx <= '0;
                r_out.frame_count <= (r_count != '0) ? r_count - 1'b1 : r_count;
            end
            if (i_cmd.emit) begin
                r_out.status <= ST_FETCHED;
                r_out.data_byte <= r_rdata;
                r_out.frame_length <= 5'(r_rlen);
                r_out.removed_count <= '0;
                r_out.last <= o_stat.bytes_done;
                r_ridx <= r_ridx + 1'b1;
            end
            if (i_cmd.result) begin
                r_out.status <= (r_in.action == ACT_FETCH) ? ST_NONE : ST_CLEARED;
                r_out.data_byte <= '0;
                r_out.frame_length <= '0;
                r_out.frame_count <= r_count;
                r_out.removed_count <= (r_in.action == ACT_FETCH) ? 5'd0 : r_removed;
                r_out.last <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/typed_frame_pool_queue.sv */
// typed_frame_pool_queue: top level, joins sequencer and datapath
// depends on tfpq_pkg, tfpq_ctrl, tfpq_dp
//
// input channel carries one transaction per store byte, fetch or clear;
// output channel carries result transactions, last marks the final one
// store byte: a result only on the byte marked last
// fetch: each queue entry walked is checked, then the match is unlinked
// and its bytes are read, captured and emitted; none found gives a result
// clear: each entry is checked, each match is unlinked, then one result
// the walk visits at most POOL_BLOCKS entries, set by the single link table
// once the last result is taken the sequencer returns to idle before the next input
// frames of FRAME_BYTES or more bytes are dropped, as are frames with no block
// reset (synchronous, active low) chains all blocks onto the free list and
// empties the queue; the payload memory is not cleared
// a stalled receiver holds the output register and the sequencer waits
// a new transaction is taken only once the previous one is fully delivered
`default_nettype none
module typed_frame_pool_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tfpq_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tfpq_pkg::t_out_item  o_out_data
);
    import tfpq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    tfpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .i_action   (i_in_data.action),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // pool, links and payload
    tfpq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_take  (i_in_valid && o_in_ready),
        .i_in       (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out_data),
        .o_out_valid(o_out_valid)
    );
endmodule
`default_nettype wire
